### design/tcm_pkg.sv
// tcm_pkg: shared types and constants for the timecode marker matcher
// no dependencies
`default_nettype none
package tcm_pkg;
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_TC    = 2'd2;

  localparam logic [5:0] FPS_DEFAULT = 6'd30;
  localparam logic [7:0] TOL_DEFAULT = 8'd3;
  localparam logic [23:0] GAP_DEFAULT = 24'd48000;

  localparam logic [1:0] CFG_FPS = 2'd0;
  localparam logic [1:0] CFG_TOL = 2'd1;
  localparam logic [1:0] CFG_GAP = 2'd2;

  localparam logic RES_MATCH = 1'b0;
  localparam logic RES_UNMAPPED = 1'b1;

  // word passed from front to back over the cmd_valid / cmd_stall handshake
  typedef struct packed {
    logic [1:0]  req;
    logic [23:0] frames;
    logic [11:0] name_id;
    logic [39:0] pos;
  } tcm_cmd_t;
endpackage
`default_nettype wire

### design/tcm_front.sv
// tcm_front: accepts input words, converts timecode digits to absolute frames
// depends on tcm_pkg
`default_nettype none
module tcm_front import tcm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [23:0] entry_frames,
  input  wire logic [11:0] entry_name_id,
  input  wire logic [1:0]  hr_tens,
  input  wire logic [3:0]  hr_ones,
  input  wire logic [2:0]  min_tens,
  input  wire logic [3:0]  min_ones,
  input  wire logic [2:0]  sec_tens,
  input  wire logic [3:0]  sec_ones,
  input  wire logic [1:0]  frm_tens,
  input  wire logic [3:0]  frm_ones,
  input  wire logic [39:0] sample_position,
  input  wire logic [5:0]  fps,
  output logic             cmd_valid,
  input  wire logic        cmd_stall,
  output tcm_cmd_t         cmd
);
  // stage 1: seconds total; stage 2: multiply by fps and add frames
  logic        s1_valid;
  logic [1:0]  s1_req;
  logic [23:0] s1_frames;
  logic [11:0] s1_name;
  logic [39:0] s1_pos;
  logic [6:0]  s1_ff;
  logic [17:0] s1_secs;
  logic [6:0]  hh, mm, ss, ff;
  logic [17:0] secs_sum;
  logic [23:0] prod;

  assign hh = 7'(hr_tens) * 7'd10 + 7'(hr_ones);
  assign mm = 7'(min_tens) * 7'd10 + 7'(min_ones);
  assign ss = 7'(sec_tens) * 7'd10 + 7'(sec_ones);
  assign ff = 7'(frm_tens) * 7'd10 + 7'(frm_ones);
  assign secs_sum = (18'(hh) * 18'd60 + 18'(mm)) * 18'd60 + 18'(ss);

  assign in_stall = s1_valid | cmd_valid;
  assign prod = 24'(s1_secs) * 24'(fps) + 24'(s1_ff);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      cmd_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid <= 1'b1;
      end else if (s1_valid) begin
        s1_valid <= 1'b0;
      end
      if (s1_valid) begin
        cmd_valid <= 1'b1;
      end else if (cmd_valid && !cmd_stall) begin
        cmd_valid <= 1'b0;
      end
    end
    if (in_valid && !in_stall) begin
      s1_req <= req_type;
      s1_frames <= entry_frames;
      s1_name <= entry_name_id;
      s1_pos <= sample_position;
      s1_ff <= ff;
      s1_secs <= secs_sum;
    end
    if (s1_valid) begin
      cmd.req <= s1_req;
      cmd.frames <= (s1_req == REQ_TC) ? prod : s1_frames;
      cmd.name_id <= s1_name;
      cmd.pos <= s1_pos;
    end
  end
endmodule
`default_nettype wire

### design/tcm_back.sv
// tcm_back: table memory, nearest-entry scan, repeat and unmapped filtering
// depends on tcm_pkg
`default_nettype none
module tcm_back import tcm_pkg::*; #(
  parameter int TABLE_DEPTH = 4096,
  parameter int UNMAPPED_LIMIT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  output logic             cmd_stall,
  input  wire tcm_cmd_t    cmd,
  input  wire logic [7:0]  tol,
  input  wire logic [23:0] gap,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             result_kind,
  output logic [11:0]      matched_index,
  output logic [11:0]      matched_name_id,
  output logic [23:0]      timecode_frames,
  output logic [39:0]      event_position
);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int UW = $clog2(UNMAPPED_LIMIT + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_NAME = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;

  logic [23:0] mem_frames [TABLE_DEPTH];
  logic [11:0] mem_names [TABLE_DEPTH];
  logic [23:0] rd_frames;
  logic [11:0] rd_name;
  logic [AW-1:0] rd_addr;

  logic [2:0]  state;
  logic [CW-1:0] count;
  logic [CW-1:0] scan_idx;
  logic        rd_pend;
  logic [AW-1:0] rd_idx;
  tcm_cmd_t    cur;
  logic        found;
  logic [AW-1:0] best_idx;
  logic [8:0]  best_dev;
  logic        last_valid;
  logic [11:0] last_id;
  logic [39:0] last_pos;
  logic        unm_valid;
  logic [23:0] unm_frames;
  logic [UW-1:0] unm_count;

  logic        take;
  logic [24:0] diff;
  logic [23:0] abs_delta;
  logic        better;
  logic [40:0] pdiff;
  logic        suppress;

  assign take = cmd_valid && !cmd_stall;
  assign cmd_stall = (state != ST_IDLE) || out_valid;

  assign diff = {1'b0, cur.frames} - {1'b0, rd_frames};
  assign abs_delta = diff[24] ? 24'(-diff) : diff[23:0];
  assign better = (abs_delta <= 24'(tol)) && ({15'd0, abs_delta[8:0]} == abs_delta)
                  && (abs_delta[8:0] < best_dev);
  assign pdiff = {1'b0, cur.pos} - {1'b0, last_pos};
  assign suppress = last_valid && (rd_name == last_id)
                    && (pdiff[40] || (pdiff[39:0] < {16'd0, gap}));

  always_comb begin
    rd_addr = scan_idx[AW-1:0];
    if (state == ST_NAME) begin
      rd_addr = best_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (take && cmd.req == REQ_LOAD && count < CW'(TABLE_DEPTH)) begin
      mem_frames[count[AW-1:0]] <= cmd.frames;
      mem_names[count[AW-1:0]] <= cmd.name_id;
    end
    rd_frames <= mem_frames[rd_addr];
    rd_name <= mem_names[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      out_valid <= 1'b0;
      last_valid <= 1'b0;
      last_id <= '0;
      last_pos <= '0;
      unm_valid <= 1'b0;
      unm_frames <= '0;
      unm_count <= '0;
      rd_pend <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (take) begin
            cur <= cmd;
            case (cmd.req)
              REQ_LOAD: begin
                if (count < CW'(TABLE_DEPTH)) begin
                  count <= count + CW'(1);
                end
              end
              REQ_CLEAR: count <= '0;
              REQ_TC: begin
                state <= ST_SCAN;
                scan_idx <= '0;
                found <= 1'b0;
                best_dev <= 9'({1'b0, tol} + 9'd1);
                rd_pend <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (rd_pend && better) begin
            found <= 1'b1;
            best_idx <= rd_idx;
            best_dev <= abs_delta[8:0];
          end
          if (scan_idx < count) begin
            rd_pend <= 1'b1;
            rd_idx <= scan_idx[AW-1:0];
            scan_idx <= scan_idx + CW'(1);
          end else begin
            rd_pend <= 1'b0;
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_NAME;
        end
        ST_NAME: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          state <= ST_IDLE;
          timecode_frames <= cur.frames;
          event_position <= cur.pos;
          if (found) begin
            if (!suppress) begin
              last_valid <= 1'b1;
              last_id <= rd_name;
              last_pos <= cur.pos;
              out_valid <= 1'b1;
              result_kind <= RES_MATCH;
              matched_index <= 12'(best_idx);
              matched_name_id <= rd_name;
            end
          end else if (!(unm_valid && cur.frames == unm_frames)) begin
            unm_valid <= 1'b1;
            unm_frames <= cur.frames;
            if (unm_count < UW'(UNMAPPED_LIMIT)) begin
              unm_count <= unm_count + UW'(1);
              out_valid <= 1'b1;
              result_kind <= RES_UNMAPPED;
              matched_index <= '0;
              matched_name_id <= '0;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### design/timecode_marker_matcher_unit.sv
// timecode_marker_matcher_unit: top level, config registers, front and back
// depends on tcm_pkg, tcm_front, tcm_back
//
//  channel | handshake            | words
//  in      | in_valid / in_stall  | load, clear or decoded timecode
//  out     | out_valid / out_stall| matched marker or unmapped timecode
//  cfg     | cfg_we               | frame_rate, tolerance, min_gap_samples
//
// load and clear need no scan; a timecode scans the table memory read port
// one entry per cycle, then drains, reads the best entry's name and decides
// reset clears counts and filter state; table contents stay undefined
// a waiting result stalls the back end; the front holds one word meanwhile
`default_nettype none
module timecode_marker_matcher_unit import tcm_pkg::*; #(
  parameter int TABLE_DEPTH = 4096,
  parameter int UNMAPPED_LIMIT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [23:0] entry_frames,
  input  wire logic [11:0] entry_name_id,
  input  wire logic [1:0]  hr_tens,
  input  wire logic [3:0]  hr_ones,
  input  wire logic [2:0]  min_tens,
  input  wire logic [3:0]  min_ones,
  input  wire logic [2:0]  sec_tens,
  input  wire logic [3:0]  sec_ones,
  input  wire logic [1:0]  frm_tens,
  input  wire logic [3:0]  frm_ones,
  input  wire logic [39:0] sample_position,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             result_kind,
  output logic [11:0]      matched_index,
  output logic [11:0]      matched_name_id,
  output logic [23:0]      timecode_frames,
  output logic [39:0]      event_position
);
  logic [5:0]  frame_rate;
  logic [7:0]  tolerance;
  logic [23:0] min_gap;
  logic [5:0]  fps;
  logic [7:0]  tol;
  logic        cmd_valid;
  logic        cmd_stall;
  tcm_cmd_t    cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rate <= FPS_DEFAULT;
      tolerance <= TOL_DEFAULT;
      min_gap <= GAP_DEFAULT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FPS: frame_rate <= cfg_data[5:0];
        CFG_TOL: tolerance <= cfg_data[7:0];
        CFG_GAP: min_gap <= cfg_data;
        default: ;
      endcase
    end
  end

  assign fps = (frame_rate == 6'd0) ? FPS_DEFAULT : frame_rate;
  assign tol = (tolerance == 8'd0) ? TOL_DEFAULT : tolerance;

  tcm_front u_front (
    .clk, .rst, .in_valid, .in_stall, .req_type, .entry_frames, .entry_name_id,
    .hr_tens, .hr_ones, .min_tens, .min_ones, .sec_tens, .sec_ones,
    .frm_tens, .frm_ones, .sample_position, .fps,
    .cmd_valid, .cmd_stall, .cmd
  );

  tcm_back #(.TABLE_DEPTH(TABLE_DEPTH), .UNMAPPED_LIMIT(UNMAPPED_LIMIT)) u_back (
    .clk, .rst, .cmd_valid, .cmd_stall, .cmd, .tol, .gap(min_gap),
    .out_valid, .out_stall, .result_kind, .matched_index, .matched_name_id,
    .timecode_frames, .event_position
  );
endmodule
`default_nettype wire
